### rtl/process_scheduler_with_best_fit_top_macros.svh
// Assertion macros for the process scheduler checker.
// Used by the checker module only.
`ifndef PROCESS_SCHEDULER_WITH_BEST_FIT_TOP_MACROS_SVH
`define PROCESS_SCHEDULER_WITH_BEST_FIT_TOP_MACROS_SVH
// implication checked every clock outside reset
`define PSBF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define PSBF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

### rtl/psbf_pkg.sv
// Package for the process scheduler: widths, codes, request and result types.
// No dependencies.
`default_nettype none
package psbf_pkg;
   localparam int MaxProcs = 16;
   localparam int NumParts = 6;
   localparam int SlotW = 4;
   localparam int CntW = 5;
   localparam int AddrW = 5;

   localparam logic [1:0] KIND_LOAD_OK = 2'd0;
   localparam logic [1:0] KIND_LOAD_REJ = 2'd1;
   localparam logic [1:0] KIND_TRANS = 2'd2;
   localparam logic [1:0] KIND_TICK = 2'd3;

   localparam logic [2:0] ST_NEW = 3'd0;
   localparam logic [2:0] ST_READY = 3'd1;
   localparam logic [2:0] ST_RUN = 3'd2;
   localparam logic [2:0] ST_WAIT = 3'd3;
   localparam logic [2:0] ST_TERM = 3'd4;

   localparam logic [1:0] MODE_PRIO = 2'd1;
   localparam logic [1:0] MODE_RR = 2'd2;

   localparam logic [2:0] REG_MODE = 3'd0;
   localparam logic [2:0] REG_QUANTUM = 3'd1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] proc_id;
      logic [7:0] mem_need;
      logic [15:0] arrive_at;
      logic [15:0] cpu_need;
      logic [15:0] io_every;
      logic [15:0] io_ticks;
      logic [7:0] prio;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [31:0] at_time;
      logic [7:0] trans_id;
      logic [2:0] from_state;
      logic [2:0] to_state;
      logic [2:0] part_no;
      logic       all_done;
      logic       last;
   } rsp_type;
endpackage
`default_nettype wire

### rtl/psbf_if.sv
// Valid/ready channel interface carrying one payload struct.
// Depends on psbf_pkg.
`default_nettype none
interface psbf_req_if;
   logic valid;
   logic ready;
   psbf_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface psbf_rsp_if;
   logic valid;
   logic ready;
   psbf_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/process_scheduler_with_best_fit_top.sv
// Process scheduler with best-fit partitions: the whole block.
// Depends on psbf_pkg and the channel interfaces in psbf_if.sv.
//
// Use: load transactions (cmd 0) fill a 16-entry process table and return one
// result. Tick transactions (cmd 1) run one scheduler step and return every
// state change in order, then a tick-end result; last marks the final one.
// Registers are written over the csr_ APB port; the user must do so only while
// the block is idle, which the block itself does not enforce. A tick is done
// by one sequencer that walks the process table, then the memory-wait, I/O-wait
// and ready queues, and best fit scans the six partitions one per cycle. Only
// one transaction is in work at a time; req ready is low meanwhile.
// Results leave through one output register; while rsp is stalled the
// sequencer holds at that result.
// Reset: clears the table count, queues, partitions, running slot, time and
// loads register defaults. Table entries need no clearing.
`default_nettype none
module process_scheduler_with_best_fit_top (
   input  wire logic clock,
   input  wire logic reset,
   psbf_req_if.sink req,
   psbf_rsp_if.source rsp,
   input  wire logic csr_psel,
   input  wire logic csr_penable,
   input  wire logic csr_pwrite,
   input  wire logic [psbf_pkg::AddrW-1:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   localparam int N = psbf_pkg::MaxProcs;
   localparam int P = psbf_pkg::NumParts;
   localparam int SW = psbf_pkg::SlotW;
   localparam int CW = psbf_pkg::CntW;

   // sequencer states
   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_DONE_SCAN = 5'd1;
   localparam logic [4:0] S_ARR_SCAN = 5'd2;
   localparam logic [4:0] S_BF = 5'd3;
   localparam logic [4:0] S_BF_END = 5'd4;
   localparam logic [4:0] S_MW_SCAN = 5'd5;
   localparam logic [4:0] S_IO_SCAN = 5'd6;
   localparam logic [4:0] S_PREEMPT = 5'd7;
   localparam logic [4:0] S_DISP = 5'd8;
   localparam logic [4:0] S_PRIO = 5'd9;
   localparam logic [4:0] S_DISP_GO = 5'd10;
   localparam logic [4:0] S_RUN = 5'd11;
   localparam logic [4:0] S_TICK_END = 5'd12;
   localparam logic [4:0] S_EMIT = 5'd13;
   localparam logic [4:0] S_DROP = 5'd14;

   // configuration
   logic [1:0] mode_ff;
   logic [15:0] quantum_ff;
   logic [7:0] psize_ff [P];

   // process table (flip-flop store, entries read at the sequencer slot)
   logic [7:0] t_id [N];
   logic [7:0] t_mem [N];
   logic [15:0] t_arr [N];
   logic [16:0] t_rem [N];
   logic [15:0] t_ioi [N];
   logic [16:0] t_ion [N];
   logic [15:0] t_iol [N];
   logic [16:0] t_iolf [N];
   logic [7:0] t_prio [N];
   logic [2:0] t_st [N];
   logic [2:0] t_part [N];

   logic [CW-1:0] count_ff;
   logic [P-1:0] pbusy_ff;

   // FIFOs: ready, io wait, memory wait
   logic [SW-1:0] rq [N];
   logic [SW-1:0] iq [N];
   logic [SW-1:0] mq [N];
   logic [CW-1:0] rq_len_ff, iq_len_ff, mq_len_ff;

   logic run_valid_ff;
   logic [SW-1:0] run_slot_ff;
   logic [15:0] slice_ff;
   logic [31:0] now_ff;

   logic [4:0] state_ff;
   logic [4:0] ret_ff;        // state after a queue drop
   logic [CW-1:0] idx_ff;     // table / queue walk index
   logic [SW-1:0] slot_ff;    // process under admission
   logic bf_from_mq_ff;       // admission comes from mem-wait queue
   logic [2:0] bf_p_ff;       // partition under scan
   logic [2:0] bf_best_ff;    // best partition +1, 0 none
   logic [8:0] bf_least_ff;   // 9'h1FF acts as none
   logic [CW-1:0] pick_ff;
   logic [1:0] dq_ff;         // queue to drop from: 0 ready 1 io 2 mem
   logic [CW-1:0] dpos_ff;

   psbf_pkg::rsp_type out_ff;
   logic out_valid_ff;

   // APB
   logic wr_en;
   logic [2:0] reg_idx;
   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx = csr_paddr[4:2];
   always_comb begin
      csr_prdata = 32'd0;
      case (reg_idx)
         psbf_pkg::REG_MODE: csr_prdata = {30'd0, mode_ff};
         psbf_pkg::REG_QUANTUM: csr_prdata = {16'd0, quantum_ff};
         default: csr_prdata = {24'd0, psize_ff[reg_idx - 3'd2]};
      endcase
   end

   assign req.ready = (state_ff == S_IDLE) && !out_valid_ff;
   assign rsp.valid = out_valid_ff;
   assign rsp.data = out_ff;

   // shared compare datapath: best-fit step
   logic [7:0] cur_psize;
   logic [7:0] cur_need;
   logic [8:0] leftover;
   logic fit_ok;
   assign cur_psize = psize_ff[bf_p_ff];
   assign cur_need = t_mem[slot_ff];
   assign leftover = {1'b0, cur_psize} - {1'b0, cur_need};
   assign fit_ok = !pbusy_ff[bf_p_ff] && (cur_psize >= cur_need) && (leftover < bf_least_ff);

   logic [SW-1:0] idx_s;
   assign idx_s = idx_ff[SW-1:0];
   logic [SW-1:0] rs;
   assign rs = run_slot_ff;

   // queue entry at walk index
   logic [SW-1:0] mq_at, iq_at, rq_at, rq_pick;
   assign mq_at = mq[idx_s];
   assign iq_at = iq[idx_s];
   assign rq_at = rq[idx_s];
   assign rq_pick = rq[pick_ff[SW-1:0]];

   logic emit_busy;
   assign emit_busy = out_valid_ff && !rsp.ready;

   // build a result record of any kind
   function automatic psbf_pkg::rsp_type mk(input logic [1:0] k, input logic [31:0] t,
         input logic [7:0] id, input logic [2:0] f, input logic [2:0] to,
         input logic [2:0] p, input logic d, input logic l);
      psbf_pkg::rsp_type r;
      r.kind = k; r.at_time = t; r.trans_id = id; r.from_state = f;
      r.to_state = to; r.part_no = p; r.all_done = d; r.last = l;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (out_valid_ff && rsp.ready) out_valid_ff <= 1'b0;
      if (wr_en) begin
         case (reg_idx)
            psbf_pkg::REG_MODE: mode_ff <= csr_pwdata[1:0];
            psbf_pkg::REG_QUANTUM: quantum_ff <= csr_pwdata[15:0];
            default: if (reg_idx <= 3'd7) psize_ff[reg_idx - 3'd2] <= csr_pwdata[7:0];
         endcase
      end
      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               if (!req.data.cmd) begin
                  out_valid_ff <= 1'b1;
                  if (count_ff < CW'(N)) begin
                     t_id[count_ff[SW-1:0]] <= req.data.proc_id;
                     t_mem[count_ff[SW-1:0]] <= req.data.mem_need;
                     t_arr[count_ff[SW-1:0]] <= req.data.arrive_at;
                     t_rem[count_ff[SW-1:0]] <= {1'b0, req.data.cpu_need};
                     t_ioi[count_ff[SW-1:0]] <= req.data.io_every;
                     t_ion[count_ff[SW-1:0]] <= {1'b0, req.data.io_every};
                     t_iol[count_ff[SW-1:0]] <= req.data.io_ticks;
                     t_iolf[count_ff[SW-1:0]] <= {1'b0, req.data.io_ticks};
                     t_prio[count_ff[SW-1:0]] <= req.data.prio;
                     t_st[count_ff[SW-1:0]] <= psbf_pkg::ST_NEW;
                     t_part[count_ff[SW-1:0]] <= 3'd0;
                     count_ff <= count_ff + 1'b1;
                     out_ff <= mk(psbf_pkg::KIND_LOAD_OK, now_ff, req.data.proc_id,
                        3'd0, 3'd0, 3'd0, 1'b0, 1'b1);
                  end else begin
                     out_ff <= mk(psbf_pkg::KIND_LOAD_REJ, now_ff, req.data.proc_id,
                        3'd0, 3'd0, 3'd0, 1'b0, 1'b1);
                  end
               end else begin
                  idx_ff <= '0;
                  state_ff <= S_DONE_SCAN;
               end
            end
         end
         // all-done check, one entry per cycle
         S_DONE_SCAN: begin
            if (idx_ff == count_ff) begin
               if (!emit_busy) begin
                  out_valid_ff <= 1'b1;
                  out_ff <= mk(psbf_pkg::KIND_TICK, now_ff, 8'd0, 3'd0, 3'd0, 3'd0,
                     1'b1, 1'b1);
                  state_ff <= S_IDLE;
               end
            end else if (t_st[idx_s] != psbf_pkg::ST_TERM) begin
               idx_ff <= '0;
               state_ff <= S_ARR_SCAN;
            end else idx_ff <= idx_ff + 1'b1;
         end
         // arrivals
         S_ARR_SCAN: begin
            if (idx_ff == count_ff) begin
               idx_ff <= '0;
               state_ff <= S_MW_SCAN;
            end else if (t_st[idx_s] == psbf_pkg::ST_NEW &&
                  {16'd0, t_arr[idx_s]} == now_ff) begin
               slot_ff <= idx_s;
               bf_from_mq_ff <= 1'b0;
               bf_p_ff <= 3'd0;
               bf_best_ff <= 3'd0;
               bf_least_ff <= 9'h1FF;
               state_ff <= S_BF;
            end else idx_ff <= idx_ff + 1'b1;
         end
         // best fit, one partition per cycle
         S_BF: begin
            if (fit_ok) begin
               bf_least_ff <= leftover;
               bf_best_ff <= bf_p_ff + 3'd1;
            end
            if (bf_p_ff == 3'(P - 1)) state_ff <= S_BF_END;
            else bf_p_ff <= bf_p_ff + 3'd1;
         end
         S_BF_END: begin
            if (bf_best_ff != 3'd0) begin
               if (!emit_busy) begin
                  pbusy_ff[bf_best_ff - 3'd1] <= 1'b1;
                  t_part[slot_ff] <= bf_best_ff;
                  t_st[slot_ff] <= psbf_pkg::ST_READY;
                  rq[rq_len_ff[SW-1:0]] <= slot_ff;
                  rq_len_ff <= rq_len_ff + 1'b1;
                  out_valid_ff <= 1'b1;
                  out_ff <= mk(psbf_pkg::KIND_TRANS, now_ff, t_id[slot_ff],
                     psbf_pkg::ST_NEW, psbf_pkg::ST_READY, bf_best_ff, 1'b0, 1'b0);
                  if (bf_from_mq_ff) begin
                     dq_ff <= 2'd2;
                     dpos_ff <= idx_ff;
                     ret_ff <= S_MW_SCAN;
                     state_ff <= S_DROP;
                  end else begin
                     idx_ff <= idx_ff + 1'b1;
                     state_ff <= S_ARR_SCAN;
                  end
               end
            end else if (bf_from_mq_ff) begin
               idx_ff <= idx_ff + 1'b1;
               state_ff <= S_MW_SCAN;
            end else begin
               mq[mq_len_ff[SW-1:0]] <= slot_ff;
               mq_len_ff <= mq_len_ff + 1'b1;
               idx_ff <= idx_ff + 1'b1;
               state_ff <= S_ARR_SCAN;
            end
         end
         // memory-wait retry
         S_MW_SCAN: begin
            if (idx_ff >= mq_len_ff) begin
               idx_ff <= '0;
               state_ff <= S_IO_SCAN;
            end else begin
               slot_ff <= mq_at;
               bf_from_mq_ff <= 1'b1;
               bf_p_ff <= 3'd0;
               bf_best_ff <= 3'd0;
               bf_least_ff <= 9'h1FF;
               state_ff <= S_BF;
            end
         end
         // I/O countdown
         S_IO_SCAN: begin
            if (idx_ff >= iq_len_ff) begin
               state_ff <= S_PREEMPT;
            end else if (t_iolf[iq_at] <= 17'd1) begin
               if (!emit_busy) begin
                  t_st[iq_at] <= psbf_pkg::ST_READY;
                  t_iolf[iq_at] <= {1'b0, t_iol[iq_at]};
                  t_ion[iq_at] <= {1'b0, t_ioi[iq_at]};
                  rq[rq_len_ff[SW-1:0]] <= iq_at;
                  rq_len_ff <= rq_len_ff + 1'b1;
                  out_valid_ff <= 1'b1;
                  out_ff <= mk(psbf_pkg::KIND_TRANS, now_ff, t_id[iq_at],
                     psbf_pkg::ST_WAIT, psbf_pkg::ST_READY, t_part[iq_at], 1'b0, 1'b0);
                  dq_ff <= 2'd1;
                  dpos_ff <= idx_ff;
                  ret_ff <= S_IO_SCAN;
                  state_ff <= S_DROP;
               end
            end else begin
               t_iolf[iq_at] <= t_iolf[iq_at] - 17'd1;
               idx_ff <= idx_ff + 1'b1;
            end
         end
         S_PREEMPT: begin
            if (mode_ff == psbf_pkg::MODE_RR && run_valid_ff && slice_ff >= quantum_ff) begin
               if (!emit_busy) begin
                  t_st[rs] <= psbf_pkg::ST_READY;
                  rq[rq_len_ff[SW-1:0]] <= rs;
                  rq_len_ff <= rq_len_ff + 1'b1;
                  run_valid_ff <= 1'b0;
                  slice_ff <= '0;
                  out_valid_ff <= 1'b1;
                  out_ff <= mk(psbf_pkg::KIND_TRANS, now_ff, t_id[rs],
                     psbf_pkg::ST_RUN, psbf_pkg::ST_READY, t_part[rs], 1'b0, 1'b0);
                  state_ff <= S_DISP;
               end
            end else state_ff <= S_DISP;
         end
         S_DISP: begin
            pick_ff <= '0;
            idx_ff <= CW'(1);
            if (!run_valid_ff && rq_len_ff != '0) begin
               state_ff <= (mode_ff == psbf_pkg::MODE_PRIO) ? S_PRIO : S_DISP_GO;
            end else state_ff <= S_RUN;
         end
         // priority search over the ready queue
         S_PRIO: begin
            if (idx_ff >= rq_len_ff) state_ff <= S_DISP_GO;
            else begin
               if (t_prio[rq_at] < t_prio[rq_pick]) pick_ff <= idx_ff;
               idx_ff <= idx_ff + 1'b1;
            end
         end
         S_DISP_GO: begin
            if (!emit_busy) begin
               if (mode_ff == psbf_pkg::MODE_RR) slice_ff <= '0;
               run_slot_ff <= rq_pick;
               run_valid_ff <= 1'b1;
               t_st[rq_pick] <= psbf_pkg::ST_RUN;
               out_valid_ff <= 1'b1;
               out_ff <= mk(psbf_pkg::KIND_TRANS, now_ff, t_id[rq_pick],
                  psbf_pkg::ST_READY, psbf_pkg::ST_RUN, t_part[rq_pick], 1'b0, 1'b0);
               dq_ff <= 2'd0;
               dpos_ff <= pick_ff;
               ret_ff <= S_RUN;
               state_ff <= S_DROP;
            end
         end
         // running process consumes the tick
         S_RUN: begin
            if (!run_valid_ff) state_ff <= S_TICK_END;
            else if (!emit_busy) begin
               if (t_rem[rs] > 17'd1) t_rem[rs] <= t_rem[rs] - 17'd1;
               else t_rem[rs] <= '0;
               if (t_ion[rs] > 17'd1) t_ion[rs] <= t_ion[rs] - 17'd1;
               if (mode_ff == psbf_pkg::MODE_RR && slice_ff != 16'hFFFF)
                  slice_ff <= slice_ff + 16'd1;
               if (t_rem[rs] <= 17'd1) begin
                  t_st[rs] <= psbf_pkg::ST_TERM;
                  if (t_part[rs] != 3'd0) pbusy_ff[t_part[rs] - 3'd1] <= 1'b0;
                  t_part[rs] <= 3'd0;
                  run_valid_ff <= 1'b0;
                  slice_ff <= '0;
                  out_valid_ff <= 1'b1;
                  out_ff <= mk(psbf_pkg::KIND_TRANS, now_ff, t_id[rs],
                     psbf_pkg::ST_RUN, psbf_pkg::ST_TERM, t_part[rs], 1'b0, 1'b0);
               end else if (t_ion[rs] <= 17'd1) begin
                  t_st[rs] <= psbf_pkg::ST_WAIT;
                  t_ion[rs] <= {1'b0, t_ioi[rs]};
                  t_iolf[rs] <= {1'b0, t_iol[rs]};
                  iq[iq_len_ff[SW-1:0]] <= rs;
                  iq_len_ff <= iq_len_ff + 1'b1;
                  run_valid_ff <= 1'b0;
                  slice_ff <= '0;
                  out_valid_ff <= 1'b1;
                  out_ff <= mk(psbf_pkg::KIND_TRANS, now_ff, t_id[rs],
                     psbf_pkg::ST_RUN, psbf_pkg::ST_WAIT, t_part[rs], 1'b0, 1'b0);
               end
               state_ff <= S_TICK_END;
            end
         end
         S_TICK_END: begin
            if (!emit_busy) begin
               out_valid_ff <= 1'b1;
               out_ff <= mk(psbf_pkg::KIND_TICK, now_ff, 8'd0, 3'd0, 3'd0, 3'd0,
                  1'b0, 1'b1);
               if (now_ff != 32'hFFFF_FFFF) now_ff <= now_ff + 32'd1;
               state_ff <= S_IDLE;
            end
         end
         // remove one queue entry, shifting one position per cycle
         S_DROP: begin
            case (dq_ff)
               2'd0: begin
                  if (dpos_ff + 1'b1 >= rq_len_ff) begin
                     rq_len_ff <= rq_len_ff - 1'b1;
                     state_ff <= ret_ff;
                  end else begin
                     rq[dpos_ff[SW-1:0]] <= rq[dpos_ff[SW-1:0] + 1'b1];
                     dpos_ff <= dpos_ff + 1'b1;
                  end
               end
               2'd1: begin
                  if (dpos_ff + 1'b1 >= iq_len_ff) begin
                     iq_len_ff <= iq_len_ff - 1'b1;
                     state_ff <= ret_ff;
                  end else begin
                     iq[dpos_ff[SW-1:0]] <= iq[dpos_ff[SW-1:0] + 1'b1];
                     dpos_ff <= dpos_ff + 1'b1;
                  end
               end
               default: begin
                  if (dpos_ff + 1'b1 >= mq_len_ff) begin
                     mq_len_ff <= mq_len_ff - 1'b1;
                     state_ff <= ret_ff;
                  end else begin
                     mq[dpos_ff[SW-1:0]] <= mq[dpos_ff[SW-1:0] + 1'b1];
                     dpos_ff <= dpos_ff + 1'b1;
                  end
               end
            endcase
         end
         default: state_ff <= S_IDLE;
      endcase
      if (reset) begin
         state_ff <= S_IDLE;
         out_valid_ff <= 1'b0;
         mode_ff <= 2'd0;
         quantum_ff <= 16'd100;
         psize_ff[0] <= 8'd40;
         psize_ff[1] <= 8'd25;
         psize_ff[2] <= 8'd15;
         psize_ff[3] <= 8'd10;
         psize_ff[4] <= 8'd8;
         psize_ff[5] <= 8'd2;
         count_ff <= '0;
         pbusy_ff <= '0;
         rq_len_ff <= '0;
         iq_len_ff <= '0;
         mq_len_ff <= '0;
         run_valid_ff <= 1'b0;
         run_slot_ff <= '0;
         slice_ff <= '0;
         now_ff <= '0;
      end
   end
endmodule
`default_nettype wire

### rtl/psbf_checker.sv
// Port-level checker for the process scheduler, bound to the top level.
// Depends on psbf_pkg, psbf_if and the macros header.
`default_nettype none
`include "process_scheduler_with_best_fit_top_macros.svh"
module psbf_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire psbf_pkg::rsp_type rsp_data
);
   `PSBF_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `PSBF_ASSERT_IMP(a_busy_while_out, clock, reset, rsp_valid, !req_ready)
   `PSBF_ASSERT_IMP(a_tick_last, clock, reset, rsp_valid && rsp_data.kind == psbf_pkg::KIND_TICK, rsp_data.last)
   `PSBF_ASSERT_IMP(a_done_tick, clock, reset, rsp_valid && rsp_data.all_done, rsp_data.kind == psbf_pkg::KIND_TICK)
   `PSBF_ASSERT_NXT(a_accept_busy, clock, reset, req_valid && req_ready, !req_ready)
endmodule

bind process_scheduler_with_best_fit_top psbf_checker u_psbf_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data));
`default_nettype wire

### tb/process_scheduler_with_best_fit_top_tb.sv
// Self-checking testbench for the process scheduler with best-fit partitions.
// Depends on psbf_pkg, psbf_if.sv and process_scheduler_with_best_fit_top.
`timescale 1ns / 100ps

module process_scheduler_with_best_fit_top_tb;
   import psbf_pkg::*;

   localparam logic       CMD_LOAD = 1'b0;
   localparam logic       CMD_TICK = 1'b1;
   localparam logic [1:0] MODE_FCFS = 2'd0;
   localparam logic [1:0] MODE_ALT = 2'd3;
   localparam logic [2:0] REG_PART0 = 3'd2;
   localparam int         MAX_OUT = 20;
   localparam int         CYCLE_LIMIT = 600000;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [AddrW-1:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   psbf_req_if req_ch ();
   psbf_rsp_if rsp_ch ();

   process_scheduler_with_best_fit_top i_dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // scheduler mirror: configuration
   logic [1:0]  cfg_mode;
   logic [15:0] cfg_quantum;
   logic [7:0]  cfg_part[NumParts];

   // scheduler mirror: process table, partitions, queues, CPU, clock
   logic [4:0]  tbl_count;
   logic [7:0]  tbl_id[MaxProcs], tbl_mem[MaxProcs], tbl_prio[MaxProcs];
   logic [15:0] tbl_arrive[MaxProcs], tbl_io_every[MaxProcs], tbl_io_len[MaxProcs];
   logic [16:0] tbl_left[MaxProcs], tbl_io_next[MaxProcs], tbl_io_left[MaxProcs];
   logic [2:0]  tbl_state[MaxProcs], tbl_part[MaxProcs];
   bit          part_taken[NumParts];
   int          ready_q[$], io_q[$], mem_q[$];
   bit          cpu_busy;
   int          cpu_slot;
   logic [15:0] slice_ticks;
   logic [31:0] sched_now;

   rsp_type     expected_q[$];
   int          step_out;
   int          fail_count, cycle_count;
   int          n_loads, n_ticks, n_results, n_done_ticks;
   bit          no_idle, hold_request;

   // ---------------------------------------------------------------- predictor
   function automatic void emit_result(logic [1:0] kind, logic [7:0] id,
                                       logic [2:0] from_s, logic [2:0] to_s,
                                       logic [2:0] part, logic done);
      rsp_type r;
      if (step_out >= MAX_OUT) return;
      r.kind = kind; r.at_time = sched_now; r.trans_id = id;
      r.from_state = from_s; r.to_state = to_s; r.part_no = part;
      r.all_done = done; r.last = 1'b0;
      expected_q.push_back(r);
      step_out++;
   endfunction

   function automatic int best_partition(logic [7:0] need);
      int best;
      int unsigned least;
      best = -1;
      least = 32'hFFFF_FFFF;
      for (int p = 0; p < NumParts; p++)
         if (!part_taken[p] && cfg_part[p] >= need && cfg_part[p] - need < least) begin
            least = cfg_part[p] - need;
            best = p;
         end
      return best;
   endfunction

   function automatic bit admit(int s);
      int p;
      p = best_partition(tbl_mem[s]);
      if (p < 0) return 0;
      part_taken[p] = 1;
      tbl_part[s] = 3'(p + 1);
      tbl_state[s] = ST_READY;
      emit_result(KIND_TRANS, tbl_id[s], ST_NEW, ST_READY, tbl_part[s], 1'b0);
      ready_q.push_back(s);
      return 1;
   endfunction

   function automatic void run_tick();
      bit all_term;
      int i, s, pick;
      bit fin, io;
      logic [2:0] p;
      all_term = 1;
      for (i = 0; i < tbl_count; i++)
         if (tbl_state[i] != ST_TERM) all_term = 0;
      if (all_term) begin
         emit_result(KIND_TICK, 8'd0, 3'd0, 3'd0, 3'd0, 1'b1);
         n_done_ticks++;
         return;
      end
      // arrivals, then retry of the memory-wait queue
      for (i = 0; i < tbl_count; i++)
         if (tbl_state[i] == ST_NEW && 32'(tbl_arrive[i]) == sched_now)
            if (!admit(i)) mem_q.push_back(i);
      i = 0;
      while (i < mem_q.size()) begin
         if (admit(mem_q[i])) mem_q.delete(i);
         else i++;
      end
      // I/O countdown
      i = 0;
      while (i < io_q.size()) begin
         s = io_q[i];
         if (tbl_io_left[s] <= 1) begin
            tbl_state[s] = ST_READY;
            tbl_io_left[s] = 17'(tbl_io_len[s]);
            tbl_io_next[s] = 17'(tbl_io_every[s]);
            emit_result(KIND_TRANS, tbl_id[s], ST_WAIT, ST_READY, tbl_part[s], 1'b0);
            ready_q.push_back(s);
            io_q.delete(i);
         end else begin
            tbl_io_left[s]--;
            i++;
         end
      end
      // quantum expiry
      if (cfg_mode == MODE_RR && cpu_busy && slice_ticks >= cfg_quantum) begin
         s = cpu_slot;
         tbl_state[s] = ST_READY;
         emit_result(KIND_TRANS, tbl_id[s], ST_RUN, ST_READY, tbl_part[s], 1'b0);
         ready_q.push_back(s);
         cpu_busy = 0;
         slice_ticks = '0;
      end
      // dispatch
      if (!cpu_busy && ready_q.size() > 0) begin
         pick = 0;
         if (cfg_mode == MODE_PRIO)
            for (i = 1; i < ready_q.size(); i++)
               if (tbl_prio[ready_q[i]] < tbl_prio[ready_q[pick]]) pick = i;
         if (cfg_mode == MODE_RR) slice_ticks = '0;
         s = ready_q[pick];
         ready_q.delete(pick);
         cpu_slot = s;
         cpu_busy = 1;
         tbl_state[s] = ST_RUN;
         emit_result(KIND_TRANS, tbl_id[s], ST_READY, ST_RUN, tbl_part[s], 1'b0);
      end
      // one tick of execution
      if (cpu_busy) begin
         s = cpu_slot;
         fin = tbl_left[s] <= 1;
         io = tbl_io_next[s] <= 1;
         if (!fin) tbl_left[s]--; else tbl_left[s] = '0;
         if (!io) tbl_io_next[s]--;
         if (cfg_mode == MODE_RR && slice_ticks < 16'hFFFF) slice_ticks++;
         if (fin) begin
            p = tbl_part[s];
            tbl_state[s] = ST_TERM;
            if (p >= 1 && p <= NumParts) part_taken[p - 1] = 0;
            emit_result(KIND_TRANS, tbl_id[s], ST_RUN, ST_TERM, p, 1'b0);
            tbl_part[s] = '0;
            cpu_busy = 0;
            slice_ticks = '0;
         end else if (io) begin
            tbl_state[s] = ST_WAIT;
            tbl_io_next[s] = 17'(tbl_io_every[s]);
            tbl_io_left[s] = 17'(tbl_io_len[s]);
            emit_result(KIND_TRANS, tbl_id[s], ST_RUN, ST_WAIT, tbl_part[s], 1'b0);
            io_q.push_back(s);
            cpu_busy = 0;
            slice_ticks = '0;
         end
      end
      emit_result(KIND_TICK, 8'd0, 3'd0, 3'd0, 3'd0, 1'b0);
      if (sched_now != 32'hFFFF_FFFF) sched_now++;
   endfunction

   function automatic void predict_step(req_type it);
      int s;
      step_out = 0;
      if (it.cmd == CMD_LOAD) begin
         n_loads++;
         if (tbl_count < MaxProcs) begin
            s = tbl_count;
            tbl_count++;
            tbl_id[s] = it.proc_id; tbl_mem[s] = it.mem_need;
            tbl_arrive[s] = it.arrive_at; tbl_left[s] = 17'(it.cpu_need);
            tbl_io_every[s] = it.io_every; tbl_io_next[s] = 17'(it.io_every);
            tbl_io_len[s] = it.io_ticks; tbl_io_left[s] = 17'(it.io_ticks);
            tbl_prio[s] = it.prio; tbl_state[s] = ST_NEW; tbl_part[s] = '0;
            emit_result(KIND_LOAD_OK, it.proc_id, 3'd0, 3'd0, 3'd0, 1'b0);
         end else
            emit_result(KIND_LOAD_REJ, it.proc_id, 3'd0, 3'd0, 3'd0, 1'b0);
      end else begin
         n_ticks++;
         run_tick();
      end
      if (step_out > 0) expected_q[expected_q.size() - 1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------- clock, limit
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending",
                  cycle_count, expected_q.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- result side
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 0;
            rsp_ch.ready <= 1'b0;
            repeat (400) @(negedge clock);
         end else
            rsp_ch.ready <= !reset && (no_idle || $urandom_range(0, 99) >= 24);
      end
   end

   task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      rsp_type a;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         a = rsp_ch.data;
         n_results++;
         if (expected_q.size() == 0) begin
            $error("unexpected result transaction, kind %0d", a.kind);
            fail_count++;
         end else begin
            e = expected_q.pop_front();
            check_field("kind", e.kind, a.kind);
            check_field("at_time", e.at_time, a.at_time);
            check_field("trans_id", e.trans_id, a.trans_id);
            check_field("from_state", e.from_state, a.from_state);
            check_field("to_state", e.to_state, a.to_state);
            check_field("part_no", e.part_no, a.part_no);
            check_field("all_done", e.all_done, a.all_done);
            check_field("last", e.last, a.last);
         end
      end
   end

   // ---------------------------------------------------------------- request side
   task automatic send_item(req_type it);
      @(negedge clock);
      while (!no_idle && $urandom_range(0, 99) < 24) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= it;
      do @(posedge clock); while (!req_ch.ready);
      predict_step(it);
   endtask

   task automatic send_tick();
      req_type it;
      it = '0;
      it.cmd = CMD_TICK;
      it.proc_id = 8'($urandom);   // ignored on a tick, toggled anyway
      send_item(it);
   endtask

   task automatic send_load(logic [7:0] id, logic [7:0] mem, logic [15:0] arr,
                            logic [15:0] cpu, logic [15:0] every, logic [15:0] len,
                            logic [7:0] prio);
      req_type it;
      it.cmd = CMD_LOAD; it.proc_id = id; it.mem_need = mem; it.arrive_at = arr;
      it.cpu_need = cpu; it.io_every = every; it.io_ticks = len; it.prio = prio;
      send_item(it);
   endtask

   // mostly short, well-formed jobs arriving soon; some full-range fields
   task automatic send_random_load();
      logic [15:0] arr, cpu, every, len;
      arr = ($urandom_range(0, 99) < 85) ? 16'(sched_now + $urandom_range(0, 4))
                                         : 16'($urandom);
      cpu = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 6)) : 16'($urandom);
      every = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 3)) : 16'($urandom);
      len = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 3)) : 16'($urandom);
      send_load(8'($urandom), ($urandom_range(0, 3) == 0) ? 8'($urandom)
                : 8'($urandom_range(0, 40)), arr, cpu, every, len, 8'($urandom));
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= AddrW'({idx, 2'b00}); csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (idx == REG_MODE) cfg_mode = value[1:0];
      else if (idx == REG_QUANTUM) cfg_quantum = value[15:0];
      else cfg_part[idx - REG_PART0] = value[7:0];
   endtask

   // sender holds back until every pending result has been taken
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic configure(logic [1:0] mode, logic [15:0] quantum,
                            logic [7:0] p0, logic [7:0] p1, logic [7:0] p2,
                            logic [7:0] p3, logic [7:0] p4, logic [7:0] p5);
      logic [7:0] sizes[NumParts];
      sizes = '{p0, p1, p2, p3, p4, p5};
      wait_drained();
      csr_write(REG_MODE, 32'(mode));
      csr_write(REG_QUANTUM, 32'(quantum));
      for (int p = 0; p < NumParts; p++) csr_write(3'(REG_PART0 + p), 32'(sizes[p]));
   endtask

   // ---------------------------------------------------------------- tests
   // empty table, extreme fields, zero CPU/I/O, memory wait, all done
   task automatic test_directed();
      configure(MODE_FCFS, 16'd100, 8'd255, 8'd25, 8'd15, 8'd10, 8'd0, 8'd2);
      send_tick();
      send_load(8'd0, 8'd255, 16'd0, 16'd0, 16'd0, 16'd0, 8'd255);
      send_load(8'd255, 8'd0, 16'd0, 16'd1, 16'd0, 16'd0, 8'd0);
      send_load(8'd7, 8'd200, 16'd0, 16'd3, 16'd1, 16'd0, 8'd1);
      send_load(8'd8, 8'd14, 16'd0, 16'd4, 16'd2, 16'd2, 8'd9);
      send_load(8'd9, 8'd255, 16'd1, 16'd2, 16'hFFFF, 16'hFFFF, 8'd3);
      repeat (18) send_tick();
   endtask

   // a process whose arrival tick has already passed never arrives
   task automatic test_late_arrival();
      send_load(8'd10, 8'd1, 16'd0, 16'd1, 16'd0, 16'd0, 8'd0);
      repeat (2) send_tick();
   endtask

   task automatic test_mode(logic [1:0] mode, logic [15:0] quantum, int loads, int ticks);
      configure(mode, quantum, 8'($urandom), 8'($urandom_range(0, 60)),
                8'($urandom_range(0, 40)), 8'($urandom_range(0, 20)),
                8'($urandom_range(0, 10)), 8'($urandom));
      repeat (loads) send_random_load();
      repeat (ticks) send_tick();
   endtask

   // result side holds off long while ticks keep coming
   task automatic test_backpressure();
      wait_drained();
      hold_request = 1;
      repeat (8) send_tick();
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      cfg_mode = MODE_FCFS; cfg_quantum = 16'd100;
      cfg_part = '{8'd40, 8'd25, 8'd15, 8'd10, 8'd8, 8'd2};
      tbl_count = '0; part_taken = '{default: 0};
      cpu_busy = 0; cpu_slot = 0; slice_ticks = '0; sched_now = '0;
      fail_count = 0; cycle_count = 0; no_idle = 0; hold_request = 0;
      n_loads = 0; n_ticks = 0; n_results = 0; n_done_ticks = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_late_arrival();
      test_mode(MODE_PRIO, 16'd7, 3, 30);
      test_mode(MODE_RR, 16'd0, 3, 25);
      test_mode(MODE_RR, 16'd1, 2, 20);
      test_backpressure();
      no_idle = 1;
      test_mode(MODE_ALT, 16'hFFFF, 2, 20);
      no_idle = 0;
      test_mode(MODE_FCFS, 16'd2, 4, 20);

      wait_drained();
      repeat (200) @(posedge clock);
      $display("covered %0d loads and %0d ticks (%0d with nothing left to run),",
               n_loads, n_ticks, n_done_ticks);
      $display("%0d results checked across all four scheduling modes", n_results);
      if (fail_count == 0 && expected_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
